// ----- sv/rfci_pkg.sv -----
// Shared types, constants and saturation helpers for the ray / finite cylinder intersector.
`timescale 1ns / 1ps
`default_nettype none
package rfci_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_STAGES    = 31;

  typedef struct packed {
    logic        ov;
    logic [31:0] v;
  } sat_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][17:0] d;
    logic [30:0]      near;
    logic             lim;
  } ray_t;

  typedef struct packed {
    ray_t        ray;
    logic [31:0] a;
    logic [31:0] b;
    logic        miss;
  } sq_side_t;

  typedef struct packed {
    ray_t ray;
    logic miss;
  } dv_side_t;

  typedef struct packed {
    logic        miss;
    logic [30:0] t;
    logic [30:0] near;
  } tail_t;

  function automatic int root_bits(input int frac);
    return (32 + frac) / 2;
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    r.ov = (x[63:31] != {33{x[63]}});
    r.v  = r.ov ? (x[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/ray_finite_cylinder_intersect.sv -----
// Ray / finite cylinder wall intersection, signed fixed point, fully pipelined.
// The pipeline holds the root stages (one bit each) and the 32 divider stages.
// Throughput: one beat per cycle while the skid entry is empty; a two-entry output stage keeps
// the pipe moving one beat past an output stall.
// Reset: synchronous, clears valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module ray_finite_cylinder_intersect import rfci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, nearest_t, zero pad
  input  wire logic [183:0] s_tdata,
  // limit_by_nearest
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z, zero pad
  output logic      [223:0] m_tdata,
  // hit
  output logic              m_tuser
);

  localparam int R  = root_bits(FRAC_BITS);
  localparam int W  = 31 + FRAC_BITS;
  localparam int DL = DIV_STAGES + 1;

  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;

  localparam logic [2:0] REG_BASE_X = 3'd0;
  localparam logic [2:0] REG_BASE_Y = 3'd1;
  localparam logic [2:0] REG_BASE_Z = 3'd2;
  localparam logic [2:0] REG_AXIS_X = 3'd3;
  localparam logic [2:0] REG_AXIS_Y = 3'd4;
  localparam logic [2:0] REG_AXIS_Z = 3'd5;
  localparam logic [2:0] REG_RADIUS = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  function automatic sat_t mq(input logic signed [63:0] p);
    return sat32(p >>> FRAC_BITS);
  endfunction

  function automatic sat_t dot3(input logic signed [63:0] p0, p1, p2);
    sat_t x0, x1, x2, s;
    x0 = mq(p0);
    x1 = mq(p1);
    x2 = mq(p2);
    s = sat32(64'($signed(x0.v)) + 64'($signed(x1.v)) + 64'($signed(x2.v)));
    s.ov = s.ov | x0.ov | x1.ov | x2.ov;
    return s;
  endfunction

  // configuration
  logic signed [31:0] base [3];
  logic signed [17:0] axis [3];
  logic        [30:0] cyl_radius;
  logic        [30:0] cyl_height;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base[0]    <= '0;
      base[1]    <= '0;
      base[2]    <= '0;
      axis[0]    <= '0;
      axis[1]    <= '0;
      axis[2]    <= ONE64[17:0];
      cyl_radius <= ONE64[30:0];
      cyl_height <= ONE64[30:0];
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_BASE_X: base[0]    <= pwdata;
        REG_BASE_Y: base[1]    <= pwdata;
        REG_BASE_Z: base[2]    <= pwdata;
        REG_AXIS_X: axis[0]    <= pwdata[17:0];
        REG_AXIS_Y: axis[1]    <= pwdata[17:0];
        REG_AXIS_Z: axis[2]    <= pwdata[17:0];
        REG_RADIUS: cyl_radius <= pwdata[30:0];
        REG_HEIGHT: cyl_height <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_BASE_X: prdata = base[0];
      REG_BASE_Y: prdata = base[1];
      REG_BASE_Z: prdata = base[2];
      REG_AXIS_X: prdata = 32'(axis[0]);
      REG_AXIS_Y: prdata = 32'(axis[1]);
      REG_AXIS_Z: prdata = 32'(axis[2]);
      REG_RADIUS: prdata = {1'b0, cyl_radius};
      REG_HEIGHT: prdata = {1'b0, cyl_height};
      default:    prdata = '0;
    endcase
  end

  // pipeline enable and input
  logic en;
  logic sk_valid;
  ray_t ray_in;

  assign en       = ~sk_valid;
  assign s_tready = en;

  always_comb begin
    ray_in.o[0] = s_tdata[31:0];
    ray_in.o[1] = s_tdata[63:32];
    ray_in.o[2] = s_tdata[95:64];
    ray_in.d[0] = s_tdata[113:96];
    ray_in.d[1] = s_tdata[131:114];
    ray_in.d[2] = s_tdata[149:132];
    ray_in.near = s_tdata[180:150];
    ray_in.lim  = s_tuser;
  end

  // stage 0: input register
  logic v0;
  ray_t r0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_tvalid;
    if (en) r0 <= ray_in;
  end

  // stage 1: origin relative to base
  logic               v1, ov1;
  ray_t               r1;
  logic signed [31:0] c1 [3];
  sat_t               c1_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      c1_next[i] = sat32(64'($signed(r0.o[i])) - 64'(base[i]));
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      r1  <= r0;
      ov1 <= c1_next[0].ov | c1_next[1].ov | c1_next[2].ov;
      for (int i = 0; i < 3; i++) c1[i] <= c1_next[i].v;
    end
  end

  // stage 2: dot product terms
  logic               v2, ov2;
  ray_t               r2;
  logic signed [35:0] pdn [3];
  logic signed [49:0] pon [3];
  logic signed [49:0] pdd [3];
  logic signed [63:0] pcc [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      r2  <= r1;
      ov2 <= ov1;
      for (int i = 0; i < 3; i++) begin
        pdn[i] <= $signed(r1.d[i]) * axis[i];
        pon[i] <= c1[i] * axis[i];
        pdd[i] <= $signed(r1.d[i]) * c1[i];
        pcc[i] <= c1[i] * c1[i];
      end
    end
  end

  // stage 3: dot sums
  logic               v3, ov3;
  ray_t               r3;
  logic signed [31:0] dn3, on3, dd3, cc3;
  sat_t               dn_next, on_next, dd_next, cc_next;

  always_comb begin
    dn_next = dot3(64'(pdn[0]), 64'(pdn[1]), 64'(pdn[2]));
    on_next = dot3(64'(pon[0]), 64'(pon[1]), 64'(pon[2]));
    dd_next = dot3(64'(pdd[0]), 64'(pdd[1]), 64'(pdd[2]));
    cc_next = dot3(pcc[0], pcc[1], pcc[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      r3  <= r2;
      ov3 <= ov2 | dn_next.ov | on_next.ov | dd_next.ov | cc_next.ov;
      dn3 <= dn_next.v;
      on3 <= on_next.v;
      dd3 <= dd_next.v;
      cc3 <= cc_next.v;
    end
  end

  // stage 4: quadratic products
  logic               v4, ov4;
  ray_t               r4;
  logic signed [31:0] dd4, cc4;
  logic signed [63:0] pnn4, pno4, poo4, prr4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      r4   <= r3;
      ov4  <= ov3;
      dd4  <= dd3;
      cc4  <= cc3;
      pnn4 <= dn3 * dn3;
      pno4 <= dn3 * on3;
      poo4 <= on3 * on3;
      prr4 <= $signed({1'b0, cyl_radius}) * $signed({1'b0, cyl_radius});
    end
  end

  // stage 5: a, b, c
  logic               v5, ov5;
  ray_t               r5;
  logic signed [31:0] a5, b5, c5;
  sat_t               nn_q, no_q, oo_q, rr_q, a_next, bd_next, b_next, cd_next, c_next;

  always_comb begin
    nn_q    = mq(pnn4);
    no_q    = mq(pno4);
    oo_q    = mq(poo4);
    rr_q    = mq(prr4);
    a_next  = sat32(ONE64 - 64'($signed(nn_q.v)));
    bd_next = sat32(64'(dd4) - 64'($signed(no_q.v)));
    b_next  = sat32(64'($signed(bd_next.v)) <<< 1);
    cd_next = sat32(64'(cc4) - 64'($signed(oo_q.v)));
    c_next  = sat32(64'($signed(cd_next.v)) - 64'($signed(rr_q.v)));
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      r5  <= r4;
      ov5 <= ov4 | nn_q.ov | no_q.ov | oo_q.ov | rr_q.ov | a_next.ov | bd_next.ov
             | b_next.ov | cd_next.ov | c_next.ov;
      a5  <= a_next.v;
      b5  <= b_next.v;
      c5  <= c_next.v;
    end
  end

  // stage 6: discriminant products
  logic               v6, ov6;
  ray_t               r6;
  logic signed [31:0] a6, b6;
  logic signed [63:0] pbb6, pac6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      r6   <= r5;
      ov6  <= ov5;
      a6   <= a5;
      b6   <= b5;
      pbb6 <= b5 * b5;
      pac6 <= a5 * c5;
    end
  end

  // stage 7: discriminant and first miss decision
  logic           v7;
  sq_side_t       side7;
  logic [W-1:0]   rad7;
  sat_t           bb_q, ac_q, ac4_q, disc_next;

  always_comb begin
    bb_q      = mq(pbb6);
    ac_q      = mq(pac6);
    ac4_q     = sat32(64'($signed(ac_q.v)) <<< 2);
    disc_next = sat32(64'($signed(bb_q.v)) - 64'($signed(ac4_q.v)));
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
    if (en) begin
      side7.ray  <= r6;
      side7.a    <= a6;
      side7.b    <= b6;
      side7.miss <= ov6 | bb_q.ov | ac_q.ov | ac4_q.ov | disc_next.ov | disc_next.v[31]
                    | (a6 <= 32'sd0);
      rad7       <= {disc_next.v[30:0], {FRAC_BITS{1'b0}}};
    end
  end

  // square root
  logic [R-1:0] sq_root;
  logic         sqv [R];
  sq_side_t     sqs [R];

  rfci_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad7),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < R; k++) sqv[k] <= 1'b0;
    end else if (en) begin
      sqv[0] <= v7;
      for (int k = 1; k < R; k++) sqv[k] <= sqv[k-1];
    end
    if (en) begin
      sqs[0] <= side7;
      for (int k = 1; k < R; k++) sqs[k] <= sqs[k-1];
    end
  end

  // stage 8: near root numerator
  logic               v8;
  dv_side_t           side8;
  logic        [31:0] num8, den8;
  logic signed [33:0] numw;

  assign numw = 34'sd0 - 34'($signed(sqs[R-1].b)) - 34'({1'b0, sq_root});

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= sqv[R-1];
    if (en) begin
      side8.ray  <= sqs[R-1].ray;
      side8.miss <= sqs[R-1].miss | numw[33];
      num8       <= numw[31:0];
      den8       <= {sqs[R-1].a[30:0], 1'b0};
    end
  end

  // division
  logic [DIV_STAGES-1:0] dv_quo;
  logic                  dv_ovf;
  logic                  dvv [DL];
  dv_side_t              dvs [DL];

  rfci_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .en  (en),
    .num (num8),
    .den (den8),
    .quo (dv_quo),
    .ovf (dv_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DL; k++) dvv[k] <= 1'b0;
    end else if (en) begin
      dvv[0] <= v8;
      for (int k = 1; k < DL; k++) dvv[k] <= dvv[k-1];
    end
    if (en) begin
      dvs[0] <= side8;
      for (int k = 1; k < DL; k++) dvs[k] <= dvs[k-1];
    end
  end

  // stage 9: distance checks and t * dir
  logic               v9;
  ray_t               r9;
  tail_t              tl9;
  logic signed [49:0] pt9 [3];

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= dvv[DL-1];
    if (en) begin
      r9       <= dvs[DL-1].ray;
      tl9.t    <= dv_quo;
      tl9.near <= dvs[DL-1].ray.near;
      tl9.miss <= dvs[DL-1].miss | dv_ovf | (dvs[DL-1].ray.lim & (dv_quo > dvs[DL-1].ray.near));
      for (int i = 0; i < 3; i++)
        pt9[i] <= $signed({1'b0, dv_quo}) * $signed(dvs[DL-1].ray.d[i]);
    end
  end

  // stage 10: hit point
  logic               v10, ov10;
  tail_t              tl10;
  logic signed [31:0] p10 [3];
  sat_t               tq [3];
  sat_t               p_next [3];
  logic               ov10_next;

  always_comb begin
    ov10_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      tq[i]     = mq(64'(pt9[i]));
      p_next[i] = sat32(64'($signed(r9.o[i])) + 64'($signed(tq[i].v)));
      ov10_next = ov10_next | tq[i].ov | p_next[i].ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
    if (en) begin
      tl10 <= tl9;
      ov10 <= ov10_next;
      for (int i = 0; i < 3; i++) p10[i] <= p_next[i].v;
    end
  end

  // stage 11: hit point relative to base
  logic               v11, ov11;
  tail_t              tl11;
  logic signed [31:0] p11 [3];
  logic signed [31:0] dp11 [3];
  sat_t               dp_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      dp_next[i] = sat32(64'(p10[i]) - 64'(base[i]));
  end

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
    if (en) begin
      tl11 <= tl10;
      ov11 <= ov10 | dp_next[0].ov | dp_next[1].ov | dp_next[2].ov;
      for (int i = 0; i < 3; i++) begin
        p11[i]  <= p10[i];
        dp11[i] <= dp_next[i].v;
      end
    end
  end

  // stage 12: axis projection terms
  logic               v12, ov12;
  tail_t              tl12;
  logic signed [31:0] p12 [3];
  logic signed [49:0] pm12 [3];

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= v11;
    if (en) begin
      tl12 <= tl11;
      ov12 <= ov11;
      for (int i = 0; i < 3; i++) begin
        p12[i]  <= p11[i];
        pm12[i] <= axis[i] * dp11[i];
      end
    end
  end

  // stage 13: projection m
  logic               v13, ov13;
  tail_t              tl13;
  logic signed [31:0] p13 [3];
  logic signed [31:0] m13;
  sat_t               m_next;

  assign m_next = dot3(64'(pm12[0]), 64'(pm12[1]), 64'(pm12[2]));

  always_ff @(posedge clk) begin
    if (rst) v13 <= 1'b0;
    else if (en) v13 <= v12;
    if (en) begin
      tl13 <= tl12;
      ov13 <= ov12 | m_next.ov;
      m13  <= m_next.v;
      for (int i = 0; i < 3; i++) p13[i] <= p12[i];
    end
  end

  // stage 14: m * axis
  logic               v14, ov14;
  tail_t              tl14;
  logic signed [31:0] p14 [3];
  logic signed [31:0] m14;
  logic signed [49:0] pq14 [3];

  always_ff @(posedge clk) begin
    if (rst) v14 <= 1'b0;
    else if (en) v14 <= v13;
    if (en) begin
      tl14 <= tl13;
      ov14 <= ov13;
      m14  <= m13;
      for (int i = 0; i < 3; i++) begin
        p14[i]  <= p13[i];
        pq14[i] <= m13 * axis[i];
      end
    end
  end

  // stage 15: axis foot point
  logic               v15, ov15;
  tail_t              tl15;
  logic signed [31:0] p15 [3];
  logic signed [31:0] q15 [3];
  logic signed [31:0] m15;
  sat_t               mq_q [3];
  sat_t               q_next [3];
  logic               ov15_next;

  always_comb begin
    ov15_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mq_q[i]   = mq(64'(pq14[i]));
      q_next[i] = sat32(64'(base[i]) + 64'($signed(mq_q[i].v)));
      ov15_next = ov15_next | mq_q[i].ov | q_next[i].ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v15 <= 1'b0;
    else if (en) v15 <= v14;
    if (en) begin
      tl15 <= tl14;
      ov15 <= ov14 | ov15_next;
      m15  <= m14;
      for (int i = 0; i < 3; i++) begin
        p15[i] <= p14[i];
        q15[i] <= q_next[i].v;
      end
    end
  end

  // normal, final hit decision, result packing
  sat_t         n_res [3];
  logic         ovn;
  logic         res_hit;
  logic [223:0] res_data;
  logic         arrive;

  always_comb begin
    ovn = 1'b0;
    for (int i = 0; i < 3; i++) begin
      n_res[i] = sat32(64'(p15[i]) - 64'(q15[i]));
      ovn      = ovn | n_res[i].ov;
    end
    res_hit = ~tl15.miss & ~ov15 & ~ovn & (m15 > 32'sd0)
              & (m15 < $signed({1'b0, cyl_height}));
    if (res_hit)
      res_data = {1'b0, n_res[2].v, n_res[1].v, n_res[0].v, p15[2], p15[1], p15[0], tl15.t};
    else
      res_data = {193'd0, tl15.near};
  end

  assign arrive = en & v15;

  // output register with skid entry
  logic         o_valid;
  logic [223:0] o_data, sk_data;
  logic         o_user, sk_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      sk_valid <= 1'b0;
    end else if (m_tready | ~o_valid) begin
      if (sk_valid) begin
        o_valid  <= 1'b1;
        sk_valid <= 1'b0;
      end else begin
        o_valid <= arrive;
      end
    end else if (arrive) begin
      sk_valid <= 1'b1;
    end
    if (m_tready | ~o_valid) begin
      if (sk_valid) begin
        o_data <= sk_data;
        o_user <= sk_user;
      end else begin
        o_data <= res_data;
        o_user <= res_hit;
      end
    end else if (arrive) begin
      sk_data <= res_data;
      sk_user <= res_hit;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;
  assign m_tuser  = o_user;

endmodule
`default_nettype wire

// ----- sv/rfci_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rfci_sqrt import rfci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [30+FRAC_BITS:0]               rad,
  output logic      [root_bits(FRAC_BITS)-1:0]     root
);

  localparam int R = root_bits(FRAC_BITS);

  logic [2*R-1:0] vpad;
  logic [R:0]     rem [R];
  logic [R-1:0]   q   [R];
  logic [2*R-1:0] vs  [R];

  assign vpad = (2*R)'(rad);

  for (genvar i = 0; i < R; i++) begin : g_st
    logic [R:0]     rp;
    logic [R-1:0]   qp;
    logic [2*R-1:0] vp;
    logic [R+2:0]   cur;
    logic [R+2:0]   trial;
    logic [R+2:0]   diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign rp = '0;
      assign qp = '0;
      assign vp = vpad;
    end else begin : g_next
      assign rp = rem[i-1];
      assign qp = q[i-1];
      assign vp = vs[i-1];
    end

    assign cur   = {rp, vp[2*R-1 -: 2]};
    assign trial = {1'b0, qp, 2'b01};
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[R:0] : cur[R:0];
        q[i]   <= {qp[R-2:0], ge};
        vs[i]  <= {vp[2*R-3:0], 2'b00};
      end
    end
  end

  assign root = q[R-1];

endmodule
`default_nettype wire

// ----- sv/rfci_div.sv -----
// Pipelined restoring divider for t = (num << FRAC_BITS) / den, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rfci_div import rfci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [31:0]             num,
  input  wire logic [31:0]             den,
  output logic      [DIV_STAGES-1:0]   quo,
  output logic                         ovf
);

  localparam int N = DIV_STAGES;

  logic [31:0]  rem [N+1];
  logic [31:0]  dn  [N+1];
  logic [N-1:0] lo  [N+1];
  logic [N-1:0] q   [N+1];
  logic         ov  [N+1];
  logic [31:0]  rem0_next;

  // quotient overflows 31 bits when the upper dividend part already reaches den
  assign rem0_next = 32'(num >> (N - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= rem0_next;
      dn[0]  <= den;
      lo[0]  <= N'(num << FRAC_BITS);
      q[0]   <= '0;
      ov[0]  <= (rem0_next >= den);
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_st
    logic [32:0] cur;
    logic [32:0] diff;
    logic        ge;

    assign cur  = {rem[k-1], lo[k-1][N-1]};
    assign ge   = (cur >= {1'b0, dn[k-1]});
    assign diff = cur - {1'b0, dn[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[31:0] : cur[31:0];
        dn[k]  <= dn[k-1];
        lo[k]  <= {lo[k-1][N-2:0], 1'b0};
        q[k]   <= {q[k-1][N-2:0], ge};
        ov[k]  <= ov[k-1];
      end
    end
  end

  assign quo = q[N];
  assign ovf = ov[N];

endmodule
`default_nettype wire

// ----- tb/ray_finite_cylinder_intersect_test.sv -----
// Self-checking bench: random and aimed rays against several cylinder setups, checked per beat.
`timescale 1ns / 1ps
module ray_finite_cylinder_intersect_test;
  import rfci_pkg::*;

  localparam longint ONE = 64'sd1 << 16;
  localparam int LAT = 80;

  typedef enum int {
    REG_BASE_X, REG_BASE_Y, REG_BASE_Z, REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z,
    REG_RADIUS, REG_HEIGHT
  } reg_idx_e;

  typedef struct {
    logic signed [31:0] o[3];
    logic signed [17:0] d[3];
    logic [30:0]        near;
    bit                 lim;
  } ray_item_t;

  typedef struct {
    bit          hit;
    logic [30:0] t;
    logic [31:0] p[3];
    logic [31:0] n[3];
  } hit_rec_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  wire [31:0] prdata;
  wire pready;
  logic s_tvalid = 0;
  wire s_tready;
  logic [183:0] s_tdata = 0;
  logic s_tuser = 0;
  wire m_tvalid;
  logic m_tready = 0;
  wire [223:0] m_tdata;
  wire m_tuser;

  ray_finite_cylinder_intersect uut (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // cylinder copy kept by the bench
  longint cb[3], ca[3], crad, chgt;
  bit ovf;
  int errors = 0, n_hits = 0, n_beats = 0;
  string xyz[3] = '{"x", "y", "z"};

  ray_item_t ray_q[$];
  hit_rec_t  hit_q[$];

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) begin ovf = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin ovf = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint qmul(longint x, longint y);
    return sat((x * y) >>> 16);
  endfunction

  function automatic longint qdot(longint ax, longint ay, longint az,
                                  longint bx, longint by, longint bz);
    return sat(qmul(ax, bx) + qmul(ay, by) + qmul(az, bz));
  endfunction

  function automatic longint root_floor(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 << 62;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else res = res >>> 1;
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic hit_rec_t cylinder_hit(ray_item_t r);
    hit_rec_t e;
    longint o[3], d[3], cc[3], p[3], nv[3];
    longint dn, on, dd, a, b, c, disc, s, num, t, m, near;
    e.hit = 0;
    e.t = r.near;
    for (int i = 0; i < 3; i++) begin e.p[i] = 0; e.n[i] = 0; end
    ovf = 0;
    near = r.near;
    for (int i = 0; i < 3; i++) begin
      o[i] = r.o[i];
      d[i] = r.d[i];
      cc[i] = sat(o[i] - cb[i]);
    end
    dn = qdot(d[0], d[1], d[2], ca[0], ca[1], ca[2]);
    on = qdot(cc[0], cc[1], cc[2], ca[0], ca[1], ca[2]);
    dd = qdot(d[0], d[1], d[2], cc[0], cc[1], cc[2]);
    a = sat(ONE - qmul(dn, dn));
    b = sat(2 * sat(dd - qmul(dn, on)));
    c = sat(qdot(cc[0], cc[1], cc[2], cc[0], cc[1], cc[2]) - qmul(on, on));
    c = sat(c - qmul(crad, crad));
    disc = sat(qmul(b, b) - sat(4 * qmul(a, c)));
    if (ovf || disc < 0 || a <= 0) return e;
    s = root_floor(disc << 16);
    num = -b - s;
    if (num < 0) return e;
    t = (num * ONE) / (2 * a);
    if (t > 64'sd2147483647) return e;
    if (r.lim && t > near) return e;
    for (int i = 0; i < 3; i++) p[i] = sat(o[i] + qmul(t, d[i]));
    m = qdot(ca[0], ca[1], ca[2], sat(p[0] - cb[0]), sat(p[1] - cb[1]), sat(p[2] - cb[2]));
    for (int i = 0; i < 3; i++) nv[i] = sat(p[i] - sat(cb[i] + qmul(m, ca[i])));
    if (ovf || m <= 0 || m >= chgt) return e;
    e.hit = 1;
    e.t = t[30:0];
    for (int i = 0; i < 3; i++) begin e.p[i] = p[i][31:0]; e.n[i] = nv[i][31:0]; end
    return e;
  endfunction

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 5'(int'(idx) * 4); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_BASE_X: cb[0] = longint'($signed(val));
      REG_BASE_Y: cb[1] = longint'($signed(val));
      REG_BASE_Z: cb[2] = longint'($signed(val));
      REG_AXIS_X: ca[0] = longint'($signed(val[17:0]));
      REG_AXIS_Y: ca[1] = longint'($signed(val[17:0]));
      REG_AXIS_Z: ca[2] = longint'($signed(val[17:0]));
      REG_RADIUS: crad = longint'(val[30:0]);
      REG_HEIGHT: chgt = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_cylinder(longint bx, longint by, longint bz, longint ax, longint ay,
                              longint az, longint r, longint h);
    reg_write(REG_BASE_X, bx[31:0]);
    reg_write(REG_BASE_Y, by[31:0]);
    reg_write(REG_BASE_Z, bz[31:0]);
    reg_write(REG_AXIS_X, ax[31:0]);
    reg_write(REG_AXIS_Y, ay[31:0]);
    reg_write(REG_AXIS_Z, az[31:0]);
    reg_write(REG_RADIUS, r[31:0]);
    reg_write(REG_HEIGHT, h[31:0]);
  endtask

  task automatic push_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                          longint dz, longint near, bit lim);
    ray_item_t r;
    r.o[0] = ox[31:0]; r.o[1] = oy[31:0]; r.o[2] = oz[31:0];
    r.d[0] = dx[17:0]; r.d[1] = dy[17:0]; r.d[2] = dz[17:0];
    r.near = near[30:0];
    r.lim = lim;
    ray_q.push_back(r);
  endtask

  task automatic push_noise();
    ray_item_t r;
    for (int i = 0; i < 3; i++) begin
      r.o[i] = $urandom;
      r.d[i] = 18'(int'($urandom_range(131072)) - 65536);
    end
    r.near = 31'($urandom);
    r.lim = $urandom_range(1);
    ray_q.push_back(r);
  endtask

  // ray from near the base, roughly unit direction
  task automatic push_aimed();
    longint dirs[4][3] = '{'{ONE, 0, 0}, '{46341, 46341, 0}, '{39322, 52429, 0},
                           '{37837, 37837, 37837}};
    longint v[3], d[3], tmp;
    int k, sh;
    k = $urandom_range(3);
    sh = $urandom_range(2);
    for (int i = 0; i < 3; i++) begin
      v[(i + sh) % 3] = dirs[k][i];
      if ($urandom_range(1)) v[(i + sh) % 3] = -v[(i + sh) % 3];
    end
    for (int i = 0; i < 3; i++) begin
      tmp = v[i] + longint'($urandom_range(128)) - 64;
      if (tmp > ONE) tmp = ONE;
      if (tmp < -ONE) tmp = -ONE;
      d[i] = tmp;
    end
    push_ray(cb[0] + longint'($urandom_range(8 * ONE)) - 4 * ONE,
             cb[1] + longint'($urandom_range(8 * ONE)) - 4 * ONE,
             cb[2] + longint'($urandom_range(8 * ONE)) - 4 * ONE,
             d[0], d[1], d[2], longint'($urandom_range(10 * ONE)), $urandom_range(1));
  endtask

  task automatic push_random(int cnt);
    repeat (cnt) begin
      if ($urandom_range(9) < 8) push_aimed();
      else push_noise();
    end
  endtask

  task automatic drain();
    while (ray_q.size() != 0 || hit_q.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  // sender
  int src_idle = 0;
  bit src_took = 0;
  bit quiet = 0;
  int hold_off = 0;
  int sink_idle = 0;

  always @(posedge clk) begin
    src_took <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      hit_q.push_back(cylinder_hit(ray_q.pop_front()));
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (src_idle > 0) begin
      src_idle <= src_idle - 1;
      s_tvalid <= 0;
    end else if ((!s_tvalid || src_took) && !quiet && $urandom_range(7) == 0) begin
      src_idle <= $urandom_range(6) - 1;
      s_tvalid <= 0;
    end else if (ray_q.size() != 0) begin
      s_tvalid <= 1;
      s_tdata <= {3'b0, ray_q[0].near, ray_q[0].d[2], ray_q[0].d[1], ray_q[0].d[0],
                  ray_q[0].o[2], ray_q[0].o[1], ray_q[0].o[0]};
      s_tuser <= ray_q[0].lim;
    end else begin
      s_tvalid <= 0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else if (sink_idle > 0) begin
      sink_idle <= sink_idle - 1;
      m_tready <= 0;
    end else if (!quiet && $urandom_range(7) == 0) begin
      sink_idle <= $urandom_range(6) - 1;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  // checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      hit_rec_t e;
      n_beats++;
      if (hit_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = hit_q.pop_front();
        if (e.hit) n_hits++;
        if (m_tuser !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, m_tuser); errors++;
        end
        if (m_tdata[30:0] !== e.t) begin
          $error("hit_t: expected %h, got %h", e.t, m_tdata[30:0]); errors++;
        end
        for (int i = 0; i < 3; i++) begin
          if (m_tdata[31 + 32 * i +: 32] !== e.p[i]) begin
            $error("point_%s: expected %h, got %h", xyz[i], e.p[i],
                   m_tdata[31 + 32 * i +: 32]);
            errors++;
          end
          if (m_tdata[127 + 32 * i +: 32] !== e.n[i]) begin
            $error("normal_%s: expected %h, got %h", xyz[i], e.n[i],
                   m_tdata[127 + 32 * i +: 32]);
            errors++;
          end
        end
        if (m_tdata[223] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_tdata[223]); errors++;
        end
      end
    end
  end

  initial begin
    cb = '{0, 0, 0};
    ca = '{0, 0, ONE};
    crad = ONE;
    chgt = ONE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset cylinder: directed cases
    push_ray(-2 * ONE, 0, ONE / 2, ONE, 0, 0, 10 * ONE, 1);       // plain hit
    push_ray(-2 * ONE, 0, ONE / 2, ONE, 0, 0, ONE / 2, 1);        // beyond nearest
    push_ray(-2 * ONE, 0, ONE / 2, ONE, 0, 0, ONE / 2, 0);        // nearest ignored
    push_ray(0, 0, -ONE, 0, 0, ONE, 10 * ONE, 0);                 // parallel to axis
    push_ray(0, 0, ONE / 2, ONE, 0, 0, 10 * ONE, 0);              // starts inside
    push_ray(2 * ONE, 0, ONE / 2, ONE, 0, 0, 10 * ONE, 0);        // moving away
    push_ray(-2 * ONE, 3 * ONE, ONE / 2, ONE, 0, 0, 10 * ONE, 0); // negative discriminant
    push_ray(-2 * ONE, 0, 2 * ONE, ONE, 0, 0, 10 * ONE, 0);       // above the top
    push_ray(-2 * ONE, 0, -ONE, ONE, 0, 0, 10 * ONE, 0);          // below the base
    push_ray(-2 * ONE, 0, 0, ONE, 0, 0, 10 * ONE, 0);             // m exactly zero
    push_ray(2147483647, 2147483647, 2147483647, ONE, ONE, ONE, 2147483647, 1);
    push_ray(-2147483648, -2147483648, -2147483648, -ONE, -ONE, -ONE, 0, 0);
    push_ray(-2 * ONE, 0, ONE / 2, -ONE, 0, 0, 0, 1);
    push_ray(0, 0, 0, 0, 0, 0, 0, 0);
    push_ray(-2 * ONE, -2 * ONE, ONE / 2, 46341, 46341, 0, 2147483647, 1);
    push_random(150);
    drain();

    set_cylinder(ONE, -ONE, 2 * ONE, 0, 0, ONE, 3 * ONE / 2, 3 * ONE);
    hold_off <= 400;
    push_random(250);
    drain();

    set_cylinder(-3 * ONE, ONE / 4, 5 * ONE, ONE, 0, 0, ONE, 2 * ONE);
    push_random(200);
    drain();

    set_cylinder(-ONE, -2 * ONE, -ONE / 2, 0, -ONE, 0, 2 * ONE, 4 * ONE);
    push_random(200);
    drain();

    // non-unit axis drives a negative a
    set_cylinder(0, 0, 0, ONE, ONE, 0, ONE, 2147483647);
    push_ray(-2 * ONE, 0, 0, ONE, ONE, 0, 10 * ONE, 0);
    push_random(80);
    drain();

    set_cylinder(2147483647, -2147483648, 2147483647, -ONE, ONE, -ONE, 2147483647, 2147483647);
    push_random(60);
    drain();

    set_cylinder(0, 0, 0, 0, 0, ONE, 0, 0);
    push_random(60);
    drain();

    set_cylinder($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (60) push_noise();
    drain();

    set_cylinder(0, 0, 0, -ONE, 0, 0, ONE, 2 * ONE);
    quiet = 1;
    push_random(320);
    drain();

    $display("Checked %0d result beats, %0d of them wall hits, over nine cylinder setups.",
             n_beats, n_hits);
    $display("Covered directed edge rays, aimed random rays, noise and a long output stall.");
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/rfci_pkg.sv
sv/rfci_sqrt.sv
sv/rfci_div.sv
sv/ray_finite_cylinder_intersect.sv
tb/ray_finite_cylinder_intersect_test.sv
